/* sv/sha_pkg.sv */
// ============================================================================
// SHA-256 hasher package
// Shared types, constants and round functions for the streaming hasher.
// ============================================================================
package sha_pkg;

    typedef logic [31:0] word_t;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned LengthPos  = 56;
    localparam logic [7:0]  PadMark    = 8'h80;
    localparam logic [0:0]  CmdAbsorb  = 1'b0;
    localparam logic [0:0]  CmdFinish  = 1'b1;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD_BYTE,   // store input byte at fill position
        OP_PAD_BYTE,    // store padding byte at fill position
        OP_START,       // copy chain words into working vars, clear round count
        OP_ROUND,       // one compression round
        OP_FOLD,        // add working vars into chain words
        OP_RESTART      // initial hash values, clear bit count
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] pad_value;
        logic       put_length;  // padding byte is taken from the bit length
        logic       bump_bits;   // add 512 to the bit count
        logic       clear_fill;
        logic       advance_fill;
        logic       latch_total;
    } sha_cmd_t;

    typedef struct packed {
        logic [5:0] fill;
        logic       round_last;
    } sha_status_t;

    function automatic word_t round_k(input logic [5:0] i);
        word_t k;
        case (i)
            6'd0:  k = 32'h428A2F98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hB5C0FBCF;
            6'd3:  k = 32'hE9B5DBA5; 6'd4:  k = 32'h3956C25B; 6'd5:  k = 32'h59F111F1;
            6'd6:  k = 32'h923F82A4; 6'd7:  k = 32'hAB1C5ED5; 6'd8:  k = 32'hD807AA98;
            6'd9:  k = 32'h12835B01; 6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
            6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE; 6'd14: k = 32'h9BDC06A7;
            6'd15: k = 32'hC19BF174; 6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
            6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC; 6'd20: k = 32'h2DE92C6F;
            6'd21: k = 32'h4A7484AA; 6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
            6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D; 6'd26: k = 32'hB00327C8;
            6'd27: k = 32'hBF597FC7; 6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
            6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27B70A85;
            6'd33: k = 32'h2E1B2138; 6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
            6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB; 6'd38: k = 32'h81C2C92E;
            6'd39: k = 32'h92722C85; 6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
            6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3; 6'd44: k = 32'hD192E819;
            6'd45: k = 32'hD6990624; 6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
            6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08; 6'd50: k = 32'h2748774C;
            6'd51: k = 32'h34B0BCB5; 6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
            6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3; 6'd56: k = 32'h748F82EE;
            6'd57: k = 32'h78A5636F; 6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
            6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB; 6'd62: k = 32'hBEF9A3F7;
            default: k = 32'hC67178F2;
        endcase
        return k;
    endfunction

    function automatic word_t initial_hash(input logic [2:0] i);
        word_t h;
        case (i)
            3'd0: h = 32'h6A09E667; 3'd1: h = 32'hBB67AE85;
            3'd2: h = 32'h3C6EF372; 3'd3: h = 32'hA54FF53A;
            3'd4: h = 32'h510E527F; 3'd5: h = 32'h9B05688C;
            3'd6: h = 32'h1F83D9AB; default: h = 32'h5BE0CD19;
        endcase
        return h;
    endfunction

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

/* sv/sha_stream_if.sv */
// ============================================================================
// Streaming channel interfaces
// Valid/ready channels for hasher commands and digest words.
// ============================================================================
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data_byte;
    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

/* sv/sha_datapath.sv */
// ============================================================================
// SHA-256 datapath
// Block bytes shift into the schedule window; round logic, chaining words, counters.
// ============================================================================
module sha_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sha_pkg::sha_cmd_t     ctl,
    input  logic [7:0]            data_byte,
    input  logic [2:0]            rd_index,
    output logic [31:0]           rd_word,
    output sha_pkg::sha_status_t  status
);
    sha_pkg::word_t    w_reg [16];       // schedule window, w_reg[0] is w[t]
    sha_pkg::word_t    v_reg [8];
    sha_pkg::word_t    h_reg [8];
    logic [5:0]        fill_reg;
    logic [5:0]        rnd_reg;
    logic [63:0]       bits_reg;
    logic [63:0]       total_reg;
    logic [7:0]        wr_byte;

    sha_pkg::word_t s0, s1, w_new, big0, big1, ch, maj, t1;

    always_comb
    begin
        s0    = sha_pkg::rotr(w_reg[1], 7) ^ sha_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1    = sha_pkg::rotr(w_reg[14], 17) ^ sha_pkg::rotr(w_reg[14], 19)
                ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        big1  = sha_pkg::rotr(v_reg[4], 6) ^ sha_pkg::rotr(v_reg[4], 11)
                ^ sha_pkg::rotr(v_reg[4], 25);
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1    = v_reg[7] + big1 + ch + sha_pkg::round_k(rnd_reg) + w_reg[0];
        big0  = sha_pkg::rotr(v_reg[0], 2) ^ sha_pkg::rotr(v_reg[0], 13)
                ^ sha_pkg::rotr(v_reg[0], 22);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        // length bytes occupy positions 56..63, most significant first
        if (ctl.op == sha_pkg::OP_LOAD_BYTE)
            wr_byte = data_byte;
        else if (ctl.put_length)
            wr_byte = total_reg[{~fill_reg[2:0], 3'd0} +: 8];
        else
            wr_byte = ctl.pad_value;
    end

    always_ff @(posedge clk)
    begin
        unique case (ctl.op) inside
            sha_pkg::OP_LOAD_BYTE, sha_pkg::OP_PAD_BYTE:
            begin
                // bytes arrive in block order, so the window fills as a shift register
                for (int i = 0; i < 15; i++)
                    w_reg[i] <= {w_reg[i][23:0], w_reg[i+1][31:24]};
                w_reg[15] <= {w_reg[15][23:0], wr_byte};
            end
            sha_pkg::OP_START:
            begin
                for (int i = 0; i < 8; i++)
                    v_reg[i] <= h_reg[i];
            end
            sha_pkg::OP_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                    w_reg[i] <= w_reg[i+1];
                w_reg[15] <= w_new;
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + big0 + maj;
            end
            default:
            begin
            end
        endcase
        if (ctl.latch_total)
            total_reg <= bits_reg + {55'd0, fill_reg, 3'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= sha_pkg::initial_hash(3'(i));
            fill_reg <= '0;
            rnd_reg  <= '0;
            bits_reg <= '0;
        end
        else
        begin
            unique case (ctl.op)
                sha_pkg::OP_START:
                    rnd_reg <= '0;
                sha_pkg::OP_ROUND:
                    rnd_reg <= rnd_reg + 6'd1;
                sha_pkg::OP_FOLD:
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                sha_pkg::OP_RESTART:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= sha_pkg::initial_hash(3'(i));
                    bits_reg <= '0;
                end
                default:
                begin
                end
            endcase
            if (ctl.bump_bits)
                bits_reg <= bits_reg + 64'd512;
            if (ctl.clear_fill)
                fill_reg <= '0;
            else if (ctl.advance_fill)
                fill_reg <= fill_reg + 6'd1;
        end
    end

    assign rd_word           = h_reg[rd_index];
    assign status.fill       = fill_reg;
    assign status.round_last = (rnd_reg == 6'd63);
endmodule

/* sv/sha_control.sv */
// ============================================================================
// SHA-256 controller
// Sequences byte loads, padding, compressions and digest output.
// ============================================================================
module sha_control (
    input  logic                  clk,
    input  logic                  rst_n,
    sha_in_if.sink                in_ch,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            out_index,
    output sha_pkg::sha_cmd_t     ctl,
    input  sha_pkg::sha_status_t  status
);
    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_START, S_ROUND, S_FOLD, S_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic       fin_reg, fin_next;      // compressing as part of finish
    logic       len_reg, len_next;      // final block with length in progress
    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_valid   = valid_reg;
    assign out_index   = idx_reg;

    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        ctl        = '0;
        ctl.op     = sha_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (in_ch.cmd == sha_pkg::CmdAbsorb)
                    begin
                        ctl.op = sha_pkg::OP_LOAD_BYTE;
                        ctl.advance_fill = 1'b1;
                        if (status.fill == 6'd63)
                        begin
                            ctl.bump_bits = 1'b1;
                            fin_next   = 1'b0;
                            state_next = S_START;
                        end
                    end
                    else
                    begin
                        ctl.op = sha_pkg::OP_PAD_BYTE;
                        ctl.pad_value = sha_pkg::PadMark;
                        ctl.latch_total = 1'b1;
                        ctl.advance_fill = 1'b1;
                        fin_next = 1'b1;
                        len_next = (status.fill < 6'(sha_pkg::LengthPos));
                        state_next = (status.fill == 6'd63) ? S_START : S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                // zero fill, then length bytes once the block is the final one
                ctl.op = sha_pkg::OP_PAD_BYTE;
                ctl.advance_fill = 1'b1;
                ctl.put_length = len_reg && (status.fill >= 6'(sha_pkg::LengthPos));
                if (status.fill == 6'd63)
                    state_next = S_START;
            end
            S_START:
            begin
                ctl.op = sha_pkg::OP_START;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                ctl.op = sha_pkg::OP_ROUND;
                if (status.round_last)
                    state_next = S_FOLD;
            end
            S_FOLD:
            begin
                ctl.op = sha_pkg::OP_FOLD;
                if (!fin_reg)
                    state_next = S_IDLE;
                else if (len_reg)
                begin
                    valid_next = 1'b1;
                    idx_next   = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    // second final block: zeros then length
                    len_next   = 1'b1;
                    state_next = S_PAD;
                end
            end
            S_EMIT:
            begin
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        valid_next = 1'b0;
                        ctl.op     = sha_pkg::OP_RESTART;
                        ctl.clear_fill = 1'b1;
                        fin_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fin_reg   <= 1'b0;
            len_reg   <= 1'b0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end
endmodule

/* sv/sha256_stream_hasher_core.sv */
// ============================================================================
// SHA-256 streaming hasher, top level
// Byte-serial SHA-256 with digest output as eight words.
// ============================================================================
// One byte is taken per transfer when the hasher is idle. The 64th byte of a
// block starts a compression (load, 64 rounds on one shared round unit, fold),
// during which no bytes are taken. A finish writes the padding one byte a
// cycle into the block buffer, runs one or two compressions, then shows the
// eight digest words, index 0 first, one per output transfer. The hasher then
// returns to the initial hash state on its own.
module sha256_stream_hasher_core (
    input  logic     clk,
    input  logic     rst_n,
    sha_in_if.sink   in_ch,
    sha_out_if.source out_ch
);
    sha_pkg::sha_cmd_t    ctl;
    sha_pkg::sha_status_t status;
    logic [2:0]           idx;
    logic                 valid;

    sha_control u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_valid (valid),
        .out_ready (out_ch.ready),
        .out_index (idx),
        .ctl       (ctl),
        .status    (status)
    );

    sha_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .data_byte (in_ch.data_byte),
        .rd_index  (idx),
        .rd_word   (out_ch.digest_word),
        .status    (status)
    );

    assign out_ch.valid      = valid;
    assign out_ch.word_index = idx;
    assign out_ch.last_word  = (idx == 3'd7);
endmodule

/* sim/sha_tb_if.sv */
// ============================================================================
// Testbench channel interfaces
// The channel interfaces come from the RTL source; this file adds the expected digest beat type.
// ============================================================================
package sha_tb_pkg;
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_beat_t;
endpackage

/* sim/sha256_stream_hasher_core_tb.sv */
// ============================================================================
// SHA-256 streaming hasher testbench
// Drives bytes and finish commands with random gaps and back-pressure, and
// checks every digest word against a behavioural SHA-256 model.
// ============================================================================
module sha256_stream_hasher_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IdleLimit = 20000;
    localparam int unsigned ItemTarget = 210;

    typedef struct {
        logic           cmd;
        logic [7:0]     data_byte;
        logic           check_word0;
        sha_pkg::word_t word0;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    sha_in_if  in_ch();
    sha_out_if out_ch();

    sha256_stream_hasher_core uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // behavioural hash state
    sha_pkg::word_t            chain[8];
    logic [7:0]                blk[64];
    logic [5:0]                fill;
    logic [63:0]               msg_bits;
    sha_tb_pkg::digest_beat_t  digest_q[$];
    int unsigned  fails = 0;
    int unsigned  idle_cycles = 0;
    int unsigned  n_sent = 0;

    function automatic sha_pkg::word_t ror(sha_pkg::word_t x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 8; i++)
            chain[i] = sha_pkg::initial_hash(3'(i));
        fill = '0;
        msg_bits = '0;
    endfunction

    function automatic void compress();
        sha_pkg::word_t w[64];
        sha_pkg::word_t v[8];
        sha_pkg::word_t t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = w[t-16] + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3))
                 + w[t-7] + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
        for (int t = 0; t < 8; t++)
            v[t] = chain[t];
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::round_k(6'(t)) + w[t];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int t = 0; t < 8; t++)
            chain[t] += v[t];
    endfunction

    // returns digest word 0 so directed rows can cross-check it
    function automatic sha_pkg::word_t hash_transfer(logic cmd, logic [7:0] b);
        logic [63:0] total;
        sha_pkg::word_t w0;
        sha_tb_pkg::digest_beat_t beat;
        if (cmd == sha_pkg::CmdAbsorb)
        begin
            blk[fill] = b;
            if (fill == 6'd63)
            begin
                compress();
                msg_bits += 64'd512;
            end
            fill = fill + 6'd1;
            return '0;
        end
        total = msg_bits + 64'(fill) * 64'd8;
        blk[fill] = sha_pkg::PadMark;
        for (int j = int'(fill) + 1; j < 64; j++)
            blk[j] = 8'h00;
        if (fill >= sha_pkg::LengthPos)
        begin
            compress();
            for (int j = 0; j < 56; j++)
                blk[j] = 8'h00;
        end
        for (int j = 0; j < 8; j++)
            blk[56 + j] = total[63 - 8*j -: 8];
        compress();
        for (int j = 0; j < 8; j++)
        begin
            beat.digest_word = chain[j];
            beat.word_index = 3'(j);
            beat.last_word = (j == 7);
            digest_q.push_back(beat);
        end
        w0 = chain[0];
        restart_hash();
        return w0;
    endfunction

    task automatic send(logic cmd, logic [7:0] b, logic chk, sha_pkg::word_t w0_exp);
        sha_pkg::word_t w0;
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
            : ($urandom_range(0, 2) == 0 ? $urandom_range(0, 3) : 0);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd <= cmd;
        in_ch.data_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        w0 = hash_transfer(cmd, b);
        n_sent++;
        if (chk && w0 !== w0_exp)
        begin
            $error("directed digest_word0: expected %h actual %h", w0_exp, w0);
            fails++;
        end
        @(negedge clk);
    endtask

    // receiver: random back-pressure, checks every transfer
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (digest_q.size() == 0)
            begin
                $error("unexpected digest word %h", out_ch.digest_word);
                fails++;
            end
            else
            begin
                sha_tb_pkg::digest_beat_t e;
                e = digest_q.pop_front();
                if (out_ch.digest_word !== e.digest_word)
                begin
                    $error("digest_word: expected %h actual %h", e.digest_word,
                           out_ch.digest_word);
                    fails++;
                end
                if (out_ch.word_index !== e.word_index)
                begin
                    $error("word_index: expected %0d actual %0d", e.word_index,
                           out_ch.word_index);
                    fails++;
                end
                if (out_ch.last_word !== e.last_word)
                begin
                    $error("last_word: expected %0d actual %0d", e.last_word,
                           out_ch.last_word);
                    fails++;
                end
            end
        end
    end

    int stall_left = 0;
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else if ($urandom_range(0, 19) == 0)
        begin
            stall_left = $urandom_range(10, 60);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    stim_row_t rows[$];

    initial
    begin
        int len;
        int lens[2] = '{120, 63};
        in_ch.valid = 1'b0;
        in_ch.cmd = sha_pkg::CmdAbsorb;
        in_ch.data_byte = 8'h00;
        restart_hash();
        for (int i = 0; i < 64; i++)
            blk[i] = 8'h00;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty message, ignored byte on finish, "abc", a four-byte message, then empty again
        rows.push_back('{sha_pkg::CmdFinish, 8'hFF, 1'b1, 32'hE3B0C442});
        rows.push_back('{sha_pkg::CmdAbsorb, 8'h61, 1'b0, '0});
        rows.push_back('{sha_pkg::CmdAbsorb, 8'h62, 1'b0, '0});
        rows.push_back('{sha_pkg::CmdAbsorb, 8'h63, 1'b0, '0});
        rows.push_back('{sha_pkg::CmdFinish, 8'h00, 1'b1, 32'hBA7816BF});
        rows.push_back('{sha_pkg::CmdAbsorb, 8'h00, 1'b0, '0});
        rows.push_back('{sha_pkg::CmdAbsorb, 8'hFF, 1'b0, '0});
        rows.push_back('{sha_pkg::CmdAbsorb, 8'hAA, 1'b0, '0});
        rows.push_back('{sha_pkg::CmdAbsorb, 8'h55, 1'b0, '0});
        rows.push_back('{sha_pkg::CmdFinish, 8'hA5, 1'b0, '0});
        rows.push_back('{sha_pkg::CmdFinish, 8'h00, 1'b1, 32'hE3B0C442});
        foreach (rows[i])
            send(rows[i].cmd, rows[i].data_byte, rows[i].check_word0, rows[i].word0);

        // full block then finish at 56 pending bytes; finish at 63 pending bytes
        foreach (lens[k])
        begin
            for (int i = 0; i < lens[k]; i++)
                send(sha_pkg::CmdAbsorb, 8'($urandom), 1'b0, '0);
            send(sha_pkg::CmdFinish, 8'($urandom), 1'b0, '0);
        end

        // random messages, mostly short, up to the item budget
        while (n_sent < ItemTarget)
        begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 130)
                                              : $urandom_range(0, 12);
            if (len > int'(ItemTarget - n_sent) - 1)
                len = int'(ItemTarget - n_sent) - 1;
            for (int i = 0; i < len; i++)
                send(sha_pkg::CmdAbsorb, 8'($urandom), 1'b0, '0);
            send(sha_pkg::CmdFinish, 8'($urandom), 1'b0, '0);
        end
        in_ch.valid <= 1'b0;

        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

/* sim.f */
sv/sha_pkg.sv
sv/sha_stream_if.sv
sv/sha_datapath.sv
sv/sha_control.sv
sv/sha256_stream_hasher_core.sv
sim/sha_tb_if.sv
sim/sha256_stream_hasher_core_tb.sv
